// ===== design/hpfa_pkg.sv =====
// Package with shared types and constants of the harmonic pair force accumulator.
`timescale 1ns / 1ps
package hpfa_pkg;

  localparam int unsigned MaxParticles = 1024;
  localparam int unsigned SpaceDims    = 3;
  localparam int unsigned AddrW        = $clog2(MaxParticles);

  // Command codes.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_PAIR   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic REG_RANGE     = 1'b0;
  localparam logic REG_STIFFNESS = 1'b1;

  localparam logic signed [47:0] ForceMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ForceMin = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [9:0]         particle_index;
    logic [9:0]         other_index;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic [31:0]        pair_distance;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic               saturated;
  } out_word_t;

  // One entry of the force memory.
  typedef struct packed {
    logic               sat;
    logic signed [47:0] fz;
    logic signed [47:0] fy;
    logic signed [47:0] fx;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_TMUL,
    S_DIV_T,
    S_WAIT_T,
    S_DIV_U,
    S_WAIT_U,
    S_DIV_C,
    S_WAIT_C,
    S_MUL,
    S_RD_A,
    S_WR_A,
    S_RD_B,
    S_WR_B,
    S_RD_Q,
    S_RD_OUT
  } state_t;

endpackage

// ===== design/hpfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module hpfa_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port; read data holds when not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/hpfa_div.sv =====
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps
module hpfa_div (
  input  logic                clk,
  input  logic                rst,
  input  hpfa_pkg::div_req_t  req,
  output hpfa_pkg::div_rsp_t  rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  count;
  logic [31:0] rem;
  logic [63:0] quot;
  logic [31:0] divisor;
  logic [32:0] trial;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {rem, quot[63]};

  // Iteration control: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == 6'd63);
      if (busy) begin
        count <= count + 6'd1;
        if (count == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quot    <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem  <= 32'(trial - {1'b0, divisor});
        quot <= {quot[62:0], 1'b1};
      end else begin
        rem  <= trial[31:0];
        quot <= {quot[62:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

  // A new division never starts while one is in flight.
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider restarted while busy");

  // Done follows the last iteration.
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (busy && count == 6'd63 && !req.start) |=> done)
    else $error("divider done missing");

  // Done appears only after a busy cycle.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(busy))
    else $error("divider done without work");

endmodule

// ===== design/harmonic_pair_force_accumulator_core.sv =====
// Top level of the harmonic pair force accumulator: sequencer, arithmetic and force memory.
// A pair word holds the block from acceptance through one multiply, three bit-serial divisions,
// the partial product steps in S_MUL and two memory read-modify-write passes; a read word raises
// out_valid after passing through S_RD_Q and S_RD_OUT (only S_RD_OUT for an out-of-range index).
// Throughput: one word at a time; skipped pairs and unused commands are taken every cycle, and a
// read waits in S_RD_OUT while an earlier result has not yet been taken.
// Reset and the clear command run a clearing pass over all MaxParticles (1024) entries of the
// force memory, during which no word is accepted; configuration writes are still taken.
`timescale 1ns / 1ps
module harmonic_pair_force_accumulator_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hpfa_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hpfa_pkg::out_word_t   out_data,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam logic [hpfa_pkg::AddrW-1:0] LastAddr =
    hpfa_pkg::AddrW'(hpfa_pkg::MaxParticles - 1);

  logic [31:0] repulsion_range;
  logic [31:0] repulsion_stiffness;

  hpfa_pkg::state_t state, state_next;
  hpfa_pkg::in_word_t word;
  logic [hpfa_pkg::AddrW-1:0] clr_addr;
  logic [2:0]  mstep;
  logic [63:0] mul_out;
  logic [31:0] t_val;
  logic [47:0] u_val;
  logic [63:0] c_val;
  logic [63:0] plo;
  logic signed [47:0] f_x, f_y, f_z;
  logic        contrib_clamp;
  logic        rd_zero;

  hpfa_pkg::div_req_t div_req;
  hpfa_pkg::div_rsp_t div_rsp;

  logic                        ram_we;
  logic [hpfa_pkg::AddrW-1:0]  ram_waddr;
  hpfa_pkg::entry_t            ram_wdata;
  logic                        ram_re;
  logic [hpfa_pkg::AddrW-1:0]  ram_raddr;
  hpfa_pkg::entry_t            ram_rdata;

  // Saturating 48-bit add; the top bit of the result flags a clamp.
  function automatic logic [48:0] sat_add(input logic signed [47:0] a,
                                          input logic signed [47:0] b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s > 49'(hpfa_pkg::ForceMax)) begin
      return {1'b1, hpfa_pkg::ForceMax};
    end else if (s < 49'(hpfa_pkg::ForceMin)) begin
      return {1'b1, hpfa_pkg::ForceMin};
    end
    return {1'b0, s[47:0]};
  endfunction

  // Magnitude of a signed Q16.16 component.
  function automatic logic [31:0] magnitude(input logic signed [31:0] v);
    return v[31] ? 32'(~v + 32'd1) : v;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      repulsion_range     <= 32'd65536;
      repulsion_stiffness <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        hpfa_pkg::REG_RANGE:     repulsion_range     <= cfg_data;
        hpfa_pkg::REG_STIFFNESS: repulsion_stiffness <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pair filter evaluated on the incoming word.
  logic pair_skip;
  logic read_oob;
  always_comb begin
    read_oob  = 32'(in_data.particle_index) >= hpfa_pkg::MaxParticles;
    pair_skip = (in_data.other_index < in_data.particle_index) || read_oob ||
                (32'(in_data.other_index) >= hpfa_pkg::MaxParticles) ||
                (in_data.pair_distance == 32'd0) ||
                (in_data.pair_distance >= repulsion_range);
  end

  assign in_ready = (state == hpfa_pkg::S_IDLE);

  // Partial product bookkeeping: step mstep processes the product of step mstep-1.
  logic [2:0]  jp;
  logic [1:0]  comp;
  logic signed [31:0] comp_disp;
  logic [31:0] comp_mag;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [95:0] full_p;
  logic        p_clamp;
  logic [46:0] p_mag;

  always_comb begin
    jp = mstep - 3'd1;
    case (state == hpfa_pkg::S_MUL ? mstep[2:1] : jp[2:1])
      2'd0:    comp_disp = word.disp_x;
      2'd1:    comp_disp = word.disp_y;
      default: comp_disp = word.disp_z;
    endcase
    comp = jp[2:1];
    if (mstep[2:1] == 2'd2 && hpfa_pkg::SpaceDims == 2) begin
      comp_mag = '0;
    end else begin
      comp_mag = magnitude(comp_disp);
    end
    if (state == hpfa_pkg::S_TMUL) begin
      mul_a = repulsion_stiffness;
      mul_b = repulsion_range - word.pair_distance;
    end else begin
      mul_a = mstep[0] ? c_val[63:32] : c_val[31:0];
      mul_b = comp_mag;
    end
    full_p  = {mul_out, 32'd0} + {32'd0, plo};
    p_clamp = |full_p[95:63];
    p_mag   = p_clamp ? hpfa_pkg::ForceMax[46:0] : full_p[62:16];
  end

  // Sign of the displacement component being finished.
  function automatic logic word_sign_of(input logic signed [31:0] v);
    return v[31];
  endfunction

  logic sign_x, sign_y, sign_z;
  assign sign_x = word_sign_of(word.disp_x);
  assign sign_y = word_sign_of(word.disp_y);
  assign sign_z = word_sign_of(word.disp_z);

  // Read-modify-write update of one memory entry.
  hpfa_pkg::entry_t upd;
  logic [48:0] sx, sy, sz;
  logic signed [47:0] ax, ay, az;
  always_comb begin
    if (state == hpfa_pkg::S_WR_B) begin
      ax = -f_x;
      ay = -f_y;
      az = -f_z;
    end else begin
      ax = f_x;
      ay = f_y;
      az = f_z;
    end
    sx = sat_add(ram_rdata.fx, ax);
    sy = sat_add(ram_rdata.fy, ay);
    sz = sat_add(ram_rdata.fz, az);
    upd.fx  = sx[47:0];
    upd.fy  = sy[47:0];
    upd.fz  = sz[47:0];
    upd.sat = ram_rdata.sat | contrib_clamp | sx[48] | sy[48] | sz[48];
  end

  // Next state, memory controls and divider requests.
  always_comb begin
    state_next       = state;
    ram_we           = 1'b0;
    ram_waddr        = clr_addr;
    ram_wdata        = '0;
    ram_re           = 1'b0;
    ram_raddr        = hpfa_pkg::AddrW'(word.particle_index);
    div_req.start    = 1'b0;
    div_req.dividend = mul_out;
    div_req.divisor  = repulsion_range;
    case (state)
      hpfa_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_data.cmd)
            hpfa_pkg::CMD_CLEAR: state_next = hpfa_pkg::S_CLEAR;
            hpfa_pkg::CMD_PAIR:  state_next = pair_skip ? hpfa_pkg::S_IDLE : hpfa_pkg::S_TMUL;
            hpfa_pkg::CMD_READ:  state_next = read_oob ? hpfa_pkg::S_RD_OUT : hpfa_pkg::S_RD_Q;
            default:             state_next = hpfa_pkg::S_IDLE;
          endcase
        end
      end
      hpfa_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == LastAddr) begin
          state_next = hpfa_pkg::S_IDLE;
        end
      end
      hpfa_pkg::S_TMUL: state_next = hpfa_pkg::S_DIV_T;
      hpfa_pkg::S_DIV_T: begin
        div_req.start = 1'b1;
        state_next    = hpfa_pkg::S_WAIT_T;
      end
      hpfa_pkg::S_WAIT_T: if (div_rsp.done) state_next = hpfa_pkg::S_DIV_U;
      hpfa_pkg::S_DIV_U: begin
        div_req.start    = 1'b1;
        div_req.dividend = {16'd0, t_val, 16'd0};
        state_next       = hpfa_pkg::S_WAIT_U;
      end
      hpfa_pkg::S_WAIT_U: if (div_rsp.done) state_next = hpfa_pkg::S_DIV_C;
      hpfa_pkg::S_DIV_C: begin
        div_req.start    = 1'b1;
        div_req.dividend = {u_val, 16'd0};
        div_req.divisor  = word.pair_distance;
        state_next       = hpfa_pkg::S_WAIT_C;
      end
      hpfa_pkg::S_WAIT_C: if (div_rsp.done) state_next = hpfa_pkg::S_MUL;
      hpfa_pkg::S_MUL: if (mstep == 3'd6) state_next = hpfa_pkg::S_RD_A;
      hpfa_pkg::S_RD_A: begin
        ram_re     = 1'b1;
        state_next = hpfa_pkg::S_WR_A;
      end
      hpfa_pkg::S_WR_A: begin
        ram_we     = 1'b1;
        ram_waddr  = hpfa_pkg::AddrW'(word.particle_index);
        ram_wdata  = upd;
        state_next = hpfa_pkg::S_RD_B;
      end
      hpfa_pkg::S_RD_B: begin
        ram_re     = 1'b1;
        ram_raddr  = hpfa_pkg::AddrW'(word.other_index);
        state_next = hpfa_pkg::S_WR_B;
      end
      hpfa_pkg::S_WR_B: begin
        ram_we     = 1'b1;
        ram_waddr  = hpfa_pkg::AddrW'(word.other_index);
        ram_wdata  = upd;
        state_next = hpfa_pkg::S_IDLE;
      end
      hpfa_pkg::S_RD_Q: begin
        ram_re     = 1'b1;
        state_next = hpfa_pkg::S_RD_OUT;
      end
      hpfa_pkg::S_RD_OUT: if (!out_valid || out_ready) state_next = hpfa_pkg::S_IDLE;
      default: state_next = hpfa_pkg::S_IDLE;
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpfa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      mstep    <= '0;
    end else begin
      if (state == hpfa_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + hpfa_pkg::AddrW'(1);
      end else begin
        clr_addr <= '0;
      end
      if (state == hpfa_pkg::S_MUL) begin
        mstep <= mstep + 3'd1;
      end else begin
        mstep <= '0;
      end
    end
  end

  // Datapath registers: accepted word, multiplier, quotients and contributions.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word          <= in_data;
      contrib_clamp <= 1'b0;
      rd_zero       <= read_oob;
    end
    mul_out <= 64'(mul_a) * 64'(mul_b);
    if (state == hpfa_pkg::S_WAIT_T && div_rsp.done) t_val <= div_rsp.quotient[31:0];
    if (state == hpfa_pkg::S_WAIT_U && div_rsp.done) u_val <= div_rsp.quotient[47:0];
    if (state == hpfa_pkg::S_WAIT_C && div_rsp.done) c_val <= div_rsp.quotient;
    if (state == hpfa_pkg::S_MUL && mstep != 3'd0) begin
      if (!jp[0]) begin
        plo <= mul_out;
      end else begin
        case (comp)
          2'd0:    f_x <= sign_x ? -48'(p_mag) : 48'(p_mag);
          2'd1:    f_y <= sign_y ? -48'(p_mag) : 48'(p_mag);
          default: f_z <= sign_z ? -48'(p_mag) : 48'(p_mag);
        endcase
        if (p_clamp) contrib_clamp <= 1'b1;
      end
    end
  end

  // Result register for read words.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == hpfa_pkg::S_RD_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hpfa_pkg::S_RD_OUT && (!out_valid || out_ready)) begin
      if (rd_zero) begin
        out_data <= '0;
      end else begin
        out_data.force_x   <= ram_rdata.fx;
        out_data.force_y   <= ram_rdata.fy;
        out_data.force_z   <= ram_rdata.fz;
        out_data.saturated <= ram_rdata.sat;
      end
    end
  end

  hpfa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  hpfa_ram #(
    .W ($bits(hpfa_pkg::entry_t)),
    .D (hpfa_pkg::MaxParticles)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A new result word only comes out of the read sequence.
  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == hpfa_pkg::S_RD_OUT)
    else $error("result word without read");

  // The second update of a pair follows the first, with S_RD_B between them.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    state == hpfa_pkg::S_WR_B |-> $past(state, 2) == hpfa_pkg::S_WR_A)
    else $error("pair updates out of order");

  // No word is taken right after reset while the memory is cleared.
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready && state == hpfa_pkg::S_CLEAR)
    else $error("word accepted during clearing pass");

endmodule

// ===== tb/sv/harmonic_pair_force_accumulator_checker.sv =====
// Checker for the harmonic pair force accumulator: predicts read results and compares them.
`timescale 1ns / 1ps
module harmonic_pair_force_accumulator_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  hpfa_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  hpfa_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  error_count,
  output int                  pending_reads
);

  localparam longint ForceHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ForceLo = -ForceHi - 1;

  longint              fx_mem [hpfa_pkg::MaxParticles];
  longint              fy_mem [hpfa_pkg::MaxParticles];
  longint              fz_mem [hpfa_pkg::MaxParticles];
  bit                  sat_mem [hpfa_pkg::MaxParticles];
  bit [31:0]           range_q;
  bit [31:0]           stiff_q;
  hpfa_pkg::out_word_t read_queue [$];

  // Zero every force and mark.
  function automatic void wipe_forces();
    for (int i = 0; i < hpfa_pkg::MaxParticles; i++) begin
      fx_mem[i] = 0;
      fy_mem[i] = 0;
      fz_mem[i] = 0;
      sat_mem[i] = 0;
    end
  endfunction

  // Scaled displacement component with magnitude clamp.
  function automatic longint scale_component(bit [63:0] coef, bit [31:0] raw, ref bit clamped);
    bit        neg;
    bit [63:0] mag;
    bit [63:0] m;
    bit [127:0] prod;
    neg = raw[31];
    mag = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
    if (mag == 0 || coef == 0) return 0;
    prod = coef * mag;
    if (prod > 128'h7FFF_FFFF_FFFF_FFFF) begin
      m = ForceHi;
      clamped = 1;
    end else begin
      m = prod[79:16];
      if (m > ForceHi) begin
        m = ForceHi;
        clamped = 1;
      end
    end
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_sum(longint a, longint b, ref bit clamped);
    longint s;
    s = a + b;
    if (s > ForceHi) begin
      clamped = 1;
      return ForceHi;
    end
    if (s < ForceLo) begin
      clamped = 1;
      return ForceLo;
    end
    return s;
  endfunction

  function automatic void add_force(int idx, longint f[3], bit contrib_clamped, longint sgn);
    bit cl;
    cl = contrib_clamped;
    fx_mem[idx] = clamp_sum(fx_mem[idx], sgn * f[0], cl);
    fy_mem[idx] = clamp_sum(fy_mem[idx], sgn * f[1], cl);
    fz_mem[idx] = clamp_sum(fz_mem[idx], sgn * f[2], cl);
    if (cl) sat_mem[idx] = 1;
  endfunction

  // Apply one accepted word to the predicted store.
  function automatic void predict_word(hpfa_pkg::in_word_t w);
    bit [127:0]          t, u, c;
    longint              f[3];
    bit                  cl;
    hpfa_pkg::out_word_t r;
    cl = 0;
    case (w.cmd)
      hpfa_pkg::CMD_CLEAR: wipe_forces();
      hpfa_pkg::CMD_PAIR: begin
        if (w.other_index >= w.particle_index && w.pair_distance != 0 &&
            w.pair_distance < range_q) begin
          t = (128'(stiff_q) * 128'(range_q - w.pair_distance)) / range_q;
          u = (t << 16) / range_q;
          c = (u << 16) / w.pair_distance;
          f[0] = scale_component(c[63:0], w.disp_x, cl);
          f[1] = scale_component(c[63:0], w.disp_y, cl);
          f[2] = (hpfa_pkg::SpaceDims == 3) ? scale_component(c[63:0], w.disp_z, cl) : 0;
          add_force(int'(w.particle_index), f, cl, 1);
          add_force(int'(w.other_index), f, cl, -1);
        end
      end
      hpfa_pkg::CMD_READ: begin
        r.force_x = fx_mem[w.particle_index][47:0];
        r.force_y = fy_mem[w.particle_index][47:0];
        r.force_z = fz_mem[w.particle_index][47:0];
        r.saturated = sat_mem[w.particle_index];
        read_queue.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Watch the channels on each rising edge.
  always @(posedge clk) begin
    hpfa_pkg::out_word_t e;
    if (rst) begin
      range_q <= 32'd65536;
      stiff_q <= 32'd65536;
      wipe_forces();
      read_queue.delete();
      error_count <= 0;
      pending_reads <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == hpfa_pkg::REG_RANGE) range_q <= cfg_data;
        else stiff_q <= cfg_data;
      end
      if (in_valid && in_ready) predict_word(in_data);
      if (out_valid && out_ready) begin
        if (read_queue.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < 10) $display("unexpected result word %h", out_data);
        end else begin
          e = read_queue.pop_front();
          if (e !== out_data) begin
            error_count <= error_count + 1;
            if (error_count < 10)
              $display("mismatch: exp x=%h y=%h z=%h s=%b got x=%h y=%h z=%h s=%b",
                       e.force_x, e.force_y, e.force_z, e.saturated, out_data.force_x,
                       out_data.force_y, out_data.force_z, out_data.saturated);
          end
        end
      end
      pending_reads <= read_queue.size();
    end
  end

endmodule

// ===== tb/sv/harmonic_pair_force_accumulator_core_tb.sv =====
// Testbench top for the harmonic pair force accumulator: stimulus, clock and verdict.
`timescale 1ns / 1ps
module harmonic_pair_force_accumulator_core_tb;

  localparam int CycleLimit = 3_000_000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  hpfa_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  hpfa_pkg::out_word_t out_data;
  logic                cfg_we;
  logic                cfg_index;
  logic [31:0]         cfg_data;
  int                  error_count;
  int                  pending_reads;
  int                  cycle_count = 0;
  int                  burst_left;
  int                  hot_idx [4];

  harmonic_pair_force_accumulator_core dut (.*);

  harmonic_pair_force_accumulator_checker checker_i (.*);

  initial clk = 0;
  always #1 clk = ~clk;

  // Receiver stalls in its own pattern: long open runs and random stall runs.
  always @(negedge clk) begin
    if (rst) out_ready <= 1;
    else if (cycle_count[9]) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one word, with bursts and gaps between them; valid stays up inside a burst.
  task automatic send_word(hpfa_pkg::in_word_t w);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_data <= w;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write once the block is idle and every result has been taken.
  task automatic write_reg(logic idx, logic [31:0] value);
    in_valid <= 0;
    @(negedge clk);
    while (!in_ready || pending_reads != 0) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic hpfa_pkg::in_word_t make_word(logic [1:0] cmd, int a, int b,
                                                   logic [31:0] dx, logic [31:0] dy,
                                                   logic [31:0] dz, logic [31:0] span);
    hpfa_pkg::in_word_t w;
    w.cmd = cmd;
    w.particle_index = 10'(a);
    w.other_index = 10'(b);
    w.disp_x = dx;
    w.disp_y = dy;
    w.disp_z = dz;
    w.pair_distance = span;
    return w;
  endfunction

  // Random word: mostly pairs among a few hot particles, mixed with reads of them and rare clears and unused commands.
  function automatic hpfa_pkg::in_word_t random_word(logic [31:0] rng);
    int a, b, pick;
    logic [31:0] pair_dist;
    pick = $urandom_range(0, 99);
    a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : hot_idx[$urandom_range(0, 3)];
    b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : hot_idx[$urandom_range(0, 3)];
    case ($urandom_range(0, 5))
      0: pair_dist = $urandom();
      1: pair_dist = rng - 1;
      2: pair_dist = $urandom_range(1, 16);
      default: pair_dist = (rng > 1) ? $urandom_range(1, rng - 1) : 1;
    endcase
    if (pick < 55) return make_word(hpfa_pkg::CMD_PAIR, (a < b) ? a : b, (a < b) ? b : a,
                                    $urandom(), $urandom(), $urandom(), pair_dist);
    if (pick < 60) return make_word(hpfa_pkg::CMD_PAIR, a, b, $urandom(), $urandom(),
                                    $urandom(), pair_dist);
    if (pick < 97) return make_word(hpfa_pkg::CMD_READ, a, $urandom_range(0, 1023), $urandom(),
                                    $urandom(), $urandom(), $urandom());
    if (pick < 98) return make_word(hpfa_pkg::CMD_UNUSED, a, b, $urandom(), $urandom(),
                                    $urandom(), $urandom());
    return make_word(hpfa_pkg::CMD_CLEAR, a, b, $urandom(), $urandom(), $urandom(), $urandom());
  endfunction

  initial begin
    logic [31:0] ranges [5];
    logic [31:0] stiffs [5];
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = hpfa_pkg::REG_RANGE;
    cfg_data = 0;
    burst_left = 0;
    ranges = '{32'd65536, 32'd1, 32'hFFFF_FFFF, 32'd4 << 16, 32'd300};
    stiffs = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd12 << 16, 32'h0100_0000};
    repeat (8) @(negedge clk);
    rst = 0;

    // Directed: extremes, each command and the skip cases.
    send_word(make_word(hpfa_pkg::CMD_PAIR, 0, 1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
                        32'd1));
    send_word(make_word(hpfa_pkg::CMD_PAIR, 5, 5, 32'h0001_0000, 32'hFFFF_0000, 32'd0,
                        32'h8000));
    send_word(make_word(hpfa_pkg::CMD_PAIR, 7, 3, 32'h0001_0000, 32'h1, 32'h1, 32'h8000));
    send_word(make_word(hpfa_pkg::CMD_PAIR, 2, 3, 32'h0001_0000, 32'h1, 32'h1, 32'd0));
    send_word(make_word(hpfa_pkg::CMD_PAIR, 2, 3, 32'h0001_0000, 32'h1, 32'h1, 32'd65536));
    send_word(make_word(hpfa_pkg::CMD_PAIR, 2, 3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'hFFFF));
    send_word(make_word(hpfa_pkg::CMD_UNUSED, 1023, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
    for (int i = 0; i < 6; i++) begin
      send_word(make_word(hpfa_pkg::CMD_PAIR, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'd1));
    end
    foreach (hot_idx[i]) hot_idx[i] = i;
    send_word(make_word(hpfa_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
    send_word(make_word(hpfa_pkg::CMD_READ, 1, 0, 0, 0, 0, 0));
    send_word(make_word(hpfa_pkg::CMD_READ, 2, 0, 0, 0, 0, 0));
    send_word(make_word(hpfa_pkg::CMD_READ, 3, 0, 0, 0, 0, 0));
    send_word(make_word(hpfa_pkg::CMD_READ, 5, 0, 0, 0, 0, 0));
    send_word(make_word(hpfa_pkg::CMD_READ, 1023, 0, 0, 0, 0, 0));
    send_word(make_word(hpfa_pkg::CMD_CLEAR, 1023, 1023, 0, 0, 0, 0));
    send_word(make_word(hpfa_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));

    // Random phases across register settings.
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        write_reg(hpfa_pkg::REG_RANGE, ranges[p % 5]);
        write_reg(hpfa_pkg::REG_STIFFNESS, stiffs[(p + 2) % 5]);
      end
      foreach (hot_idx[i]) hot_idx[i] = ($urandom_range(0, 1)) ? $urandom_range(0, 1023)
                                        : i * 341;
      for (int n = 0; n < 275; n++) send_word(random_word(ranges[p % 5]));
    end

    // Drain the outstanding reads, then allow for the block's tail.
    in_valid <= 0;
    while (pending_reads != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
design/hpfa_pkg.sv
design/hpfa_ram.sv
design/hpfa_div.sv
design/harmonic_pair_force_accumulator_core.sv
tb/sv/harmonic_pair_force_accumulator_checker.sv
tb/sv/harmonic_pair_force_accumulator_core_tb.sv
